[src/cstc_pkg.sv]
// Package: types, constants and reset values for the cooling supply temperature controller.
package cstc_pkg;

  localparam int TEMP_W   = 17;
  localparam int MARGIN_W = 16;
  localparam int RATE_W   = 10;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 17;
  localparam int STEP_W   = 19;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 24;

  localparam logic [TEMP_W-1:0] BASE_CEILING = TEMP_W'(120000);

  typedef enum logic [1:0] {
    MODE_DEFAULT    = 2'd0,
    MODE_AGGRESSIVE = 2'd1,
    MODE_INSTANT    = 2'd2,
    MODE_FIXED      = 2'd3
  } mode_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_MODE        = 3'd0,
    REG_FIXED_TEMP  = 3'd1,
    REG_EMERG_TEMP  = 3'd2,
    REG_MARGIN      = 3'd3,
    REG_RATE        = 3'd4,
    REG_LOWEST_TEMP = 3'd5,
    REG_LOW_THRESH  = 3'd6,
    REG_HIGH_THRESH = 3'd7
  } reg_idx_t;

  localparam logic [TEMP_W-1:0]   RST_FIXED_TEMP  = TEMP_W'(20000);
  localparam logic [TEMP_W-1:0]   RST_EMERG_TEMP  = TEMP_W'(30000);
  localparam logic [MARGIN_W-1:0] RST_MARGIN      = '0;
  localparam logic [RATE_W-1:0]   RST_RATE        = RATE_W'(10);
  localparam logic [TEMP_W-1:0]   RST_LOWEST_TEMP = TEMP_W'(15000);
  localparam logic [TEMP_W-1:0]   RST_LOW_THRESH  = TEMP_W'(28000);
  localparam logic [TEMP_W-1:0]   RST_HIGH_THRESH = TEMP_W'(29500);

  typedef struct packed {
    mode_t                       mode;
    logic [TEMP_W-1:0]           fixed_supply_temp;
    logic [TEMP_W-1:0]           emergency_temp;
    logic signed [MARGIN_W-1:0]  default_margin;
    logic [RATE_W-1:0]           change_rate;
    logic [TEMP_W-1:0]           lowest_supply_temp;
    logic [TEMP_W-1:0]           step_low_threshold;
    logic [TEMP_W-1:0]           step_high_threshold;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] max_inlet;
    logic [TEMP_W-1:0] max_added;
    logic [TEMP_W-1:0] supply_base;
    logic [TEMP_W-1:0] supply_temp;
  } calc_t;

endpackage

[src/cstc_cfg_regs.sv]
// Configuration register file with write port and reset values.
module cstc_cfg_regs import cstc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode                <= MODE_DEFAULT;
      cfg_r.fixed_supply_temp   <= RST_FIXED_TEMP;
      cfg_r.emergency_temp      <= RST_EMERG_TEMP;
      cfg_r.default_margin      <= RST_MARGIN;
      cfg_r.change_rate         <= RST_RATE;
      cfg_r.lowest_supply_temp  <= RST_LOWEST_TEMP;
      cfg_r.step_low_threshold  <= RST_LOW_THRESH;
      cfg_r.step_high_threshold <= RST_HIGH_THRESH;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MODE:        cfg_r.mode                <= mode_t'(cfg_wdata[1:0]);
        REG_FIXED_TEMP:  cfg_r.fixed_supply_temp   <= cfg_wdata[TEMP_W-1:0];
        REG_EMERG_TEMP:  cfg_r.emergency_temp      <= cfg_wdata[TEMP_W-1:0];
        REG_MARGIN:      cfg_r.default_margin      <= cfg_wdata[MARGIN_W-1:0];
        REG_RATE:        cfg_r.change_rate         <= cfg_wdata[RATE_W-1:0];
        REG_LOWEST_TEMP: cfg_r.lowest_supply_temp  <= cfg_wdata[TEMP_W-1:0];
        REG_LOW_THRESH:  cfg_r.step_low_threshold  <= cfg_wdata[TEMP_W-1:0];
        REG_HIGH_THRESH: cfg_r.step_high_threshold <= cfg_wdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/cstc_round_calc.sv]
// Combinational update of the running maxima, supply base and supply temperature.
module cstc_round_calc import cstc_pkg::*; (
  input  cfg_t              cfg,
  input  logic [TEMP_W-1:0] max_inlet,
  input  logic [TEMP_W-1:0] max_added,
  input  logic [TEMP_W-1:0] supply_base,
  input  logic [TEMP_W-1:0] inlet_temp,
  input  logic [TEMP_W-1:0] added_temp,
  input  logic              server_active,
  output calc_t             calc
);

  logic [TEMP_W-1:0]        hi;
  logic [TEMP_W-1:0]        add_hi;
  logic signed [STEP_W-1:0] s_base;
  logic signed [STEP_W-1:0] s_rate;
  logic signed [STEP_W-1:0] s_rate10;
  logic signed [STEP_W-1:0] s_rate20;
  logic signed [STEP_W-1:0] s_hi;
  logic signed [STEP_W-1:0] s_em;
  logic signed [STEP_W-1:0] s_lo_t;
  logic signed [STEP_W-1:0] s_hi_t;
  logic signed [STEP_W-1:0] s_lim;
  logic signed [STEP_W-1:0] s_low;
  logic signed [STEP_W-1:0] s_ceil;
  logic signed [STEP_W-1:0] stepped;
  logic signed [STEP_W-1:0] clamped;
  logic [TEMP_W-1:0]        new_base;
  logic [TEMP_W-1:0]        instant;

  always_comb begin
    hi     = (server_active && (inlet_temp > max_inlet)) ? inlet_temp : max_inlet;
    add_hi = (added_temp > max_added) ? added_temp : max_added;

    s_base   = $signed({2'b00, supply_base});
    s_rate   = $signed({{(STEP_W-RATE_W){1'b0}}, cfg.change_rate});
    s_rate10 = (s_rate <<< 3) + (s_rate <<< 1);
    s_rate20 = s_rate10 <<< 1;
    s_hi     = $signed({2'b00, hi});
    s_em     = $signed({2'b00, cfg.emergency_temp});
    s_lo_t   = $signed({2'b00, cfg.step_low_threshold});
    s_hi_t   = $signed({2'b00, cfg.step_high_threshold});
    s_low    = $signed({2'b00, cfg.lowest_supply_temp});
    s_ceil   = $signed({2'b00, BASE_CEILING});
    s_lim    = s_em + $signed({{(STEP_W-MARGIN_W){cfg.default_margin[MARGIN_W-1]}},
                               cfg.default_margin});

    if (cfg.mode == MODE_DEFAULT) begin
      stepped = (s_lim > s_hi) ? (s_base + s_rate) : (s_base - s_rate);
    end else begin
      priority if (s_hi < s_lo_t && s_base < s_em) begin
        stepped = s_base + s_rate10;
      end else if (s_hi >= s_lo_t && s_hi < s_hi_t && s_base < s_em) begin
        stepped = s_base + s_rate;
      end else if (s_hi >= s_hi_t && s_hi < s_em) begin
        stepped = s_base;
      end else begin
        stepped = s_base - s_rate20;
      end
    end

    clamped = (stepped < s_low) ? s_low : stepped;
    if (clamped > s_ceil) begin
      clamped = s_ceil;
    end
    new_base = clamped[TEMP_W-1:0];

    instant = (cfg.emergency_temp > add_hi) ? (cfg.emergency_temp - add_hi) : '0;

    calc.max_inlet = hi;
    calc.max_added = add_hi;
    unique case (cfg.mode)
      MODE_DEFAULT, MODE_AGGRESSIVE: begin
        calc.supply_base = new_base;
        calc.supply_temp = new_base;
      end
      MODE_INSTANT: begin
        calc.supply_base = supply_base;
        calc.supply_temp = instant;
      end
      default: begin
        calc.supply_base = supply_base;
        calc.supply_temp = cfg.fixed_supply_temp;
      end
    endcase
  end

endmodule

[src/cooling_supply_temp_controller.sv]
// Top level: input register, round state, result register and configuration.
//
//  channel | ports                          | content
//  in      | in_tvalid/in_tready            | tdata: inlet_temp, added_temp; tuser: active; tlast
//  out     | out_tvalid/out_tready          | tdata: supply_temp
//  cfg     | cfg_we/cfg_addr/cfg_wdata      | register write, no read-back
//
//  One item per cycle unless a last-server item waits; a last item's result is registered.
//  The round update is one pass of compare-add logic between the input and result registers.
//  Reset (synchronous, rst_n low) clears maxima, sets the base to its floor reset value.
//  A last-server item waits in the input register while the result register holds.
//  Items that are not last-server pass the input register regardless of the output side.
module cooling_supply_temp_controller import cstc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [16:0] inlet_temp, [33:17] added_temp, rest zero
  input  logic              in_tuser,   // [0] server_active
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [16:0] supply_temp, rest zero
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t              cfg;
  calc_t             calc;

  logic              s1_valid_r;
  logic [TEMP_W-1:0] s1_inlet_r;
  logic [TEMP_W-1:0] s1_added_r;
  logic              s1_active_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              out_free;
  logic              round_end;

  logic [TEMP_W-1:0] max_inlet_r;
  logic [TEMP_W-1:0] max_added_r;
  logic [TEMP_W-1:0] supply_base_r;
  logic              out_valid_r;
  logic [TEMP_W-1:0] out_data_r;

  cstc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cstc_round_calc u_calc (
    .cfg           (cfg),
    .max_inlet     (max_inlet_r),
    .max_added     (max_added_r),
    .supply_base   (supply_base_r),
    .inlet_temp    (s1_inlet_r),
    .added_temp    (s1_added_r),
    .server_active (s1_active_r),
    .calc          (calc)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign round_end = s1_adv && s1_last_r;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_inlet_r  <= in_tdata[TEMP_W-1:0];
      s1_added_r  <= in_tdata[2*TEMP_W-1:TEMP_W];
      s1_active_r <= in_tuser;
      s1_last_r   <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_inlet_r   <= '0;
      max_added_r   <= '0;
      supply_base_r <= RST_LOWEST_TEMP;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        max_inlet_r   <= '0;
        max_added_r   <= '0;
        supply_base_r <= calc.supply_base;
      end else begin
        max_inlet_r <= calc.max_inlet;
        max_added_r <= calc.max_added;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (round_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (round_end) begin
      out_data_r <= calc.supply_temp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-TEMP_W){1'b0}}, out_data_r};

`ifndef SYNTH
  a_round_clears: assert property (@(posedge clk) disable iff (!rst_n)
    round_end |=> (max_inlet_r == '0 && max_added_r == '0))
    else $error("running maxima not cleared after round end");

  a_base_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    supply_base_r <= BASE_CEILING)
    else $error("supply base above ceiling");

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    (round_end && (cfg.mode == MODE_DEFAULT || cfg.mode == MODE_AGGRESSIVE))
    |=> (out_data_r == supply_base_r))
    else $error("stepping result differs from stored base");

  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while round end is blocked");
`endif

endmodule
